### design/fwq_pkg.sv
// ----------------------------------------------------------------------------
// fwq_pkg
// Shared types and constants for the futex wait queue engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fwq_pkg;

    localparam int SLOTS     = 16;
    localparam int TASK_BITS = 8;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int IDX_W     = $clog2(SLOTS);

    localparam logic [2:0] ACT_WAIT    = 3'd0;
    localparam logic [2:0] ACT_WAKE    = 3'd1;
    localparam logic [2:0] ACT_REQUEUE = 3'd2;
    localparam logic [2:0] ACT_CANCEL  = 3'd3;
    localparam logic [2:0] ACT_QUERY   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] word_address;
        logic [31:0] second_address;
        logic [31:0] current_value;
        logic [31:0] expected_value;
        logic [7:0]  task_id;
        logic [31:0] wake_limit;
        logic [31:0] requeue_limit;
    } req_t;

    typedef struct packed {
        logic       item_kind;
        logic [1:0] status;
        logic [7:0] woken_task;
        logic [4:0] count;
        logic       last;
    } res_t;

    typedef struct packed {
        logic                 pop;
        logic                 push;
        logic [31:0]          addr;
        logic [TASK_BITS-1:0] task_id;
    } tbl_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [31:0]          head_addr;
        logic [TASK_BITS-1:0] head_task;
    } tbl_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_SUMMARY
    } state_t;

endpackage

`default_nettype wire

### design/fwq_table.sv
// ----------------------------------------------------------------------------
// fwq_table
// Arrival-ordered waiter table: pops at the head, appends at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module fwq_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fwq_pkg::tbl_cmd_t  cmd,
    output fwq_pkg::tbl_stat_t      stat
);

    logic [31:0]                   addr_reg [fwq_pkg::SLOTS];
    logic [31:0]                   addr_next [fwq_pkg::SLOTS];
    logic [fwq_pkg::TASK_BITS-1:0] task_reg [fwq_pkg::SLOTS];
    logic [fwq_pkg::TASK_BITS-1:0] task_next [fwq_pkg::SLOTS];
    logic [fwq_pkg::CNT_W-1:0]     cnt_reg;
    logic [fwq_pkg::CNT_W-1:0]     cnt_next;
    logic [fwq_pkg::CNT_W-1:0]     wpos;

    always_comb
    begin
        for (int i = 0; i < fwq_pkg::SLOTS - 1; i++)
        begin
            if (cmd.pop)
            begin
                addr_next[i] = addr_reg[i + 1];
                task_next[i] = task_reg[i + 1];
            end
            else
            begin
                addr_next[i] = addr_reg[i];
                task_next[i] = task_reg[i];
            end
        end
        addr_next[fwq_pkg::SLOTS - 1] = addr_reg[fwq_pkg::SLOTS - 1];
        task_next[fwq_pkg::SLOTS - 1] = task_reg[fwq_pkg::SLOTS - 1];
        wpos = cmd.pop ? cnt_reg - 1'b1 : cnt_reg;
        if (cmd.push)
        begin
            addr_next[wpos[fwq_pkg::IDX_W-1:0]] = cmd.addr;
            task_next[wpos[fwq_pkg::IDX_W-1:0]] = cmd.task_id;
        end
        cnt_next = cnt_reg - fwq_pkg::CNT_W'(cmd.pop) + fwq_pkg::CNT_W'(cmd.push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        task_reg <= task_next;
    end

    assign stat.count     = cnt_reg;
    assign stat.head_addr = addr_reg[0];
    assign stat.head_task = task_reg[0];

endmodule

`default_nettype wire

### design/futex_wait_queue_engine.sv
// ----------------------------------------------------------------------------
// futex_wait_queue_engine
// Futex wait queue: wait, wake, requeue, cancel and query over one table.
// ----------------------------------------------------------------------------
// A request enters on in_req when in_valid is high and in_stall is low; the
// block raises in_stall from the cycle after acceptance until the summary of
// that request has been loaded into the output register. Results leave on
// out_res under out_valid/out_stall: zero or more woken-task reports, then a
// summary with last set. The output register holds its result while
// out_stall is high, and the sequencer waits for it to drain.
// Every scanning action visits the table by rotating it once through its
// head, one entry per cycle through a single address/task comparator while
// no report waits on a stalled output; entries taken by requeue are then
// appended one by one at the tail under the second address. Wait and
// refused requests go straight from idle to the summary state.
// Reset empties the table and the output register; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module futex_wait_queue_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire fwq_pkg::req_t   in_req,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output fwq_pkg::res_t        out_res
);

    fwq_pkg::state_t    state_reg, state_next;
    fwq_pkg::req_t      req_reg, req_next;
    fwq_pkg::tbl_cmd_t  cmd;
    fwq_pkg::tbl_stat_t stat;

    logic [fwq_pkg::CNT_W-1:0]     left_reg, left_next;
    logic [fwq_pkg::CNT_W-1:0]     woken_reg, woken_next;
    logic [fwq_pkg::CNT_W-1:0]     aff_reg, aff_next;
    logic [fwq_pkg::CNT_W-1:0]     nm_reg, nm_next;
    logic                          found_reg, found_next;
    logic [1:0]                    sts_reg, sts_next;
    logic [fwq_pkg::TASK_BITS-1:0] mv_reg [fwq_pkg::SLOTS];
    logic [fwq_pkg::TASK_BITS-1:0] mv_next [fwq_pkg::SLOTS];
    logic                          out_valid_reg, out_valid_next;
    fwq_pkg::res_t                 out_reg, out_next;

    logic        accept, out_free, addr_hit, task_hit, active, can_wake;
    logic [2:0]  act;
    logic [31:0] wlimit, rlimit;

    fwq_table u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .stat (stat)
    );

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign act      = req_reg.action;
    assign wlimit   = req_reg.wake_limit;
    assign rlimit   = (act == fwq_pkg::ACT_WAKE) ? 32'd0 : req_reg.requeue_limit;

    // The one comparator unit: the head entry against the request key.
    assign addr_hit = stat.head_addr == req_reg.word_address;
    assign task_hit = stat.head_task == fwq_pkg::TASK_BITS'(req_reg.task_id);
    assign can_wake = 32'(woken_reg) < wlimit;
    assign active   = can_wake || (32'(nm_reg) < rlimit);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        left_next      = left_reg;
        woken_next     = woken_reg;
        aff_next       = aff_reg;
        nm_next        = nm_reg;
        found_next     = found_reg;
        sts_next       = sts_reg;
        mv_next        = mv_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        cmd            = '0;
        in_stall       = state_reg != fwq_pkg::S_IDLE;

        unique case (state_reg)
            fwq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = in_req;
                    left_next  = stat.count;
                    woken_next = '0;
                    aff_next   = '0;
                    nm_next    = '0;
                    found_next = 1'b0;
                    sts_next   = fwq_pkg::ST_OK;
                    state_next = fwq_pkg::S_SCAN;
                    priority if (in_req.action > fwq_pkg::ACT_QUERY)
                    begin
                        sts_next   = fwq_pkg::ST_BAD;
                        state_next = fwq_pkg::S_SUMMARY;
                    end
                    else if (in_req.action != fwq_pkg::ACT_CANCEL
                             && (in_req.word_address == 32'd0
                                 || (in_req.action == fwq_pkg::ACT_REQUEUE
                                     && in_req.second_address == 32'd0)))
                    begin
                        sts_next   = fwq_pkg::ST_BAD;
                        state_next = fwq_pkg::S_SUMMARY;
                    end
                    else if (in_req.action == fwq_pkg::ACT_WAIT)
                    begin
                        state_next = fwq_pkg::S_SUMMARY;
                        priority if (in_req.current_value != in_req.expected_value)
                            sts_next = fwq_pkg::ST_MISMATCH;
                        else if (stat.count >= fwq_pkg::CNT_W'(fwq_pkg::SLOTS))
                            sts_next = fwq_pkg::ST_FULL;
                        else
                        begin
                            cmd.push    = 1'b1;
                            cmd.addr    = in_req.word_address;
                            cmd.task_id = fwq_pkg::TASK_BITS'(in_req.task_id);
                        end
                    end
                    else
                    begin
                        state_next = fwq_pkg::S_SCAN;
                    end
                end
            end

            fwq_pkg::S_SCAN:
            begin
                if (left_reg == '0)
                begin
                    state_next = (nm_reg != '0) ? fwq_pkg::S_APPEND : fwq_pkg::S_SUMMARY;
                end
                else
                begin
                    cmd.addr    = stat.head_addr;
                    cmd.task_id = stat.head_task;
                    unique case (act)
                        fwq_pkg::ACT_CANCEL:
                        begin
                            cmd.pop   = 1'b1;
                            left_next = left_reg - 1'b1;
                            if (task_hit && !found_reg)
                                found_next = 1'b1;
                            else
                                cmd.push = 1'b1;
                        end
                        fwq_pkg::ACT_QUERY:
                        begin
                            cmd.pop   = 1'b1;
                            cmd.push  = 1'b1;
                            left_next = left_reg - 1'b1;
                            if (addr_hit)
                                aff_next = aff_reg + 1'b1;
                        end
                        default:
                        begin
                            if (addr_hit && active)
                            begin
                                if (can_wake)
                                begin
                                    // A report needs the output register.
                                    if (out_free)
                                    begin
                                        cmd.pop        = 1'b1;
                                        left_next      = left_reg - 1'b1;
                                        woken_next     = woken_reg + 1'b1;
                                        aff_next       = aff_reg + 1'b1;
                                        out_valid_next = 1'b1;
                                        out_next.item_kind  = fwq_pkg::KIND_REPORT;
                                        out_next.status     = fwq_pkg::ST_OK;
                                        out_next.woken_task = 8'(stat.head_task);
                                        out_next.count      = 5'd0;
                                        out_next.last       = 1'b0;
                                    end
                                end
                                else
                                begin
                                    cmd.pop   = 1'b1;
                                    left_next = left_reg - 1'b1;
                                    aff_next  = aff_reg + 1'b1;
                                    nm_next   = nm_reg + 1'b1;
                                    mv_next[nm_reg[fwq_pkg::IDX_W-1:0]] = stat.head_task;
                                end
                            end
                            else
                            begin
                                cmd.pop   = 1'b1;
                                cmd.push  = 1'b1;
                                left_next = left_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end

            fwq_pkg::S_APPEND:
            begin
                cmd.push    = 1'b1;
                cmd.addr    = req_reg.second_address;
                cmd.task_id = mv_reg[0];
                for (int i = 0; i < fwq_pkg::SLOTS - 1; i++)
                    mv_next[i] = mv_reg[i + 1];
                nm_next = nm_reg - 1'b1;
                if (nm_reg == fwq_pkg::CNT_W'(1))
                    state_next = fwq_pkg::S_SUMMARY;
            end

            fwq_pkg::S_SUMMARY:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.item_kind  = fwq_pkg::KIND_SUMMARY;
                    out_next.status     = sts_reg;
                    out_next.woken_task = 8'd0;
                    out_next.last       = 1'b1;
                    out_next.count      = 5'd0;
                    if (sts_reg == fwq_pkg::ST_OK)
                    begin
                        unique case (act)
                            fwq_pkg::ACT_WAKE:    out_next.count = 5'(woken_reg);
                            fwq_pkg::ACT_REQUEUE: out_next.count = 5'(aff_reg);
                            fwq_pkg::ACT_CANCEL:  out_next.count = 5'(found_reg);
                            fwq_pkg::ACT_QUERY:   out_next.count = 5'(aff_reg);
                            default:              out_next.count = 5'd0;
                        endcase
                    end
                    state_next = fwq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fwq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fwq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        left_reg  <= left_next;
        woken_reg <= woken_next;
        aff_reg   <= aff_next;
        nm_reg    <= nm_next;
        found_reg <= found_next;
        sts_reg   <= sts_next;
        mv_reg    <= mv_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire
